FILE: hw/rtl/waveform_period_generator_macros.svh
// ----------------------------------------------------------------------------
// Waveform period generator assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_PERIOD_GENERATOR_MACROS_SVH
`define WAVEFORM_PERIOD_GENERATOR_MACROS_SVH

// same-cycle implication
`define WPG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/wpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpg_pkg
// Types, codes and constants shared by the waveform period generator.
// ----------------------------------------------------------------------------
package wpg_pkg;

    localparam int PHASE_BITS_DEF         = 16;
    localparam int SINE_QUARTER_DEPTH_DEF = 256;
    localparam int unsigned MAX_PERIOD_SAMPLES = 100000;

    localparam int INDEX_W = 17;
    localparam int AMP_W   = 11;
    localparam int WAVE_W  = 8;
    localparam int ADC_W   = 12;
    localparam int CODE_W  = 10;
    localparam int CFG_W   = 17;
    localparam int MAG_W   = 16;
    localparam int AMP511_W = AMP_W + 9;
    localparam int PROD_W  = 36;

    localparam logic [INDEX_W-1:0] MIN_PERIOD = 17'd100;
    localparam logic [CODE_W-1:0]  MIDSCALE   = 10'd512;
    localparam logic [ADC_W-1:0]   ADC_TOP    = 12'd4095;
    localparam logic [AMP_W-1:0]   FULL_AMP   = 11'd1024;
    localparam logic [MAG_W-1:0]   ONE_Q15    = 16'd32768;
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic [PROD_W-1:0]  CODE_OFFSET = 36'd17179869184;

    // register indexes
    localparam logic [1:0] REG_WAVE_TYPE = 2'd0;
    localparam logic [1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [1:0] REG_PERIOD    = 2'd2;
    localparam logic [1:0] REG_POLARITY  = 2'd3;

    localparam logic [WAVE_W-1:0]  RST_WAVE_TYPE = 8'd0;
    localparam logic [AMP_W-1:0]   RST_AMPLITUDE = 11'd1024;
    localparam logic [INDEX_W-1:0] RST_PERIOD    = 17'd1000;
    localparam logic               RST_POLARITY  = 1'b1;

    // operations
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;
    localparam logic [1:0] OP_HOLD    = 2'd3;

    // report kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_MEAS = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_TRIP = 2'd3;

    // waveform types
    localparam logic [WAVE_W-1:0] WAVE_SINE      = 8'd0;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE  = 8'd1;
    localparam logic [WAVE_W-1:0] WAVE_HALF_SINE = 8'd2;
    localparam logic [WAVE_W-1:0] WAVE_HALF_TRI  = 8'd3;
    localparam logic [WAVE_W-1:0] WAVE_CONST     = 8'd4;

    localparam logic [63:0] TAYLOR_DIV [9] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                               64'd156, 64'd210, 64'd272, 64'd342};

    typedef struct packed {
        logic [1:0]       operation;
        logic [ADC_W-1:0] adc_voltage;
        logic [ADC_W-1:0] adc_current;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] dac_code;
        logic [1:0]        report_kind;
        logic [ADC_W-1:0]  voltage_echo;
        logic [ADC_W-1:0]  current_echo;
    } out_item_t;

    typedef struct packed {
        logic [WAVE_W-1:0]  wave_type;
        logic [AMP_W-1:0]   amplitude;
        logic [INDEX_W-1:0] period_n;
        logic               polarity;
    } wpg_cfg_t;

    typedef struct packed {
        logic       capture;
        logic       idx_clear;
        logic       idx_inc;
        logic       div_start;
        logic       div_step;
        logic       phase;
        logic       lookup;
        logic       mul;
        logic       out_load;
        logic       code_sel;
        logic       echo_sel;
        logic       amp_zero;
        logic [1:0] kind;
    } wpg_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       over_range;
        logic       period_end;
        logic       div_done;
    } wpg_status_t;

    // Q15 sine of a Q30 angle, Taylor series, elaboration only
    function automatic logic [MAG_W-1:0] sine_q15(input logic [63:0] x);
        logic [63:0]        t;
        logic signed [64:0] sum;
        logic [63:0]        v;
        logic [3:0]         n;
        t   = x;
        sum = $signed({1'b0, x});
        for (n = 4'd0; n < 4'd9; n++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / TAYLOR_DIV[n];
            if (n[0] == 1'b0)
                sum = sum - $signed({1'b0, t});
            else
                sum = sum + $signed({1'b0, t});
        end
        if (sum < 0)
            sum = '0;
        v = ((sum[63:0] * 64'd32768) + (64'd1 << 29)) >> 30;
        if (v > 64'd32768)
            v = 64'd32768;
        return v[MAG_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/wpg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpg_ctrl
// Sequencer: decodes each item, tracks run and trip state, steps the datapath.
// ----------------------------------------------------------------------------
module wpg_ctrl
    import wpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    output logic        result_valid,
    input  logic        result_ready,
    input  logic        amp_write,
    input  wpg_status_t status,
    output wpg_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_PHASE,
        S_LOOKUP,
        S_MUL,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       gen_reg, gen_next;
    logic       trip_reg, trip_next;
    logic [1:0] kind_reg, kind_next;
    logic       code_sel_reg, code_sel_next;
    logic       echo_reg, echo_next;
    logic       out_valid_reg, out_valid_next;
    logic       calc;
    logic       idx_clear;
    logic       idx_inc;
    logic       out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next    = state_reg;
        gen_next      = gen_reg;
        trip_next     = trip_reg;
        kind_next     = kind_reg;
        code_sel_next = code_sel_reg;
        echo_next     = echo_reg;
        calc          = 1'b0;
        idx_clear     = 1'b0;
        idx_inc       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                kind_next     = KIND_NONE;
                code_sel_next = 1'b0;
                echo_next     = 1'b0;
                unique case (status.op)
                    OP_START:
                    begin
                        gen_next      = 1'b1;
                        idx_clear     = 1'b1;
                        calc          = 1'b1;
                        code_sel_next = 1'b1;
                    end
                    OP_MEASURE:
                    begin
                        if (gen_reg)
                        begin
                            if (status.over_range)
                            begin
                                trip_next = 1'b1;
                                gen_next  = 1'b0;
                                idx_clear = 1'b1;
                                kind_next = KIND_TRIP;
                            end
                            else if (status.period_end)
                            begin
                                gen_next  = 1'b0;
                                idx_clear = 1'b1;
                                kind_next = KIND_END;
                                echo_next = 1'b1;
                            end
                            else
                            begin
                                idx_inc       = 1'b1;
                                calc          = 1'b1;
                                kind_next     = KIND_MEAS;
                                echo_next     = 1'b1;
                                code_sel_next = 1'b1;
                            end
                        end
                    end
                    OP_STOP:
                    begin
                        gen_next  = 1'b0;
                        idx_clear = 1'b1;
                    end
                    OP_HOLD:
                    begin
                        if (gen_reg)
                        begin
                            calc          = 1'b1;
                            code_sel_next = 1'b1;
                        end
                    end
                endcase
                state_next = calc ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_PHASE;
            end
            S_PHASE:  state_next = S_LOOKUP;
            S_LOOKUP: state_next = S_MUL;
            S_MUL:    state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
        if (amp_write)
            trip_next = 1'b0;
    end

    always_comb
    begin
        cmd.capture   = (state_reg == S_IDLE) && item_valid;
        cmd.idx_clear = idx_clear;
        cmd.idx_inc   = idx_inc;
        cmd.div_start = calc;
        cmd.div_step  = (state_reg == S_DIV) && !status.div_done;
        cmd.phase     = (state_reg == S_PHASE);
        cmd.lookup    = (state_reg == S_LOOKUP);
        cmd.mul       = (state_reg == S_MUL);
        cmd.out_load  = (state_reg == S_OUT) && out_free;
        cmd.code_sel  = code_sel_reg;
        cmd.echo_sel  = echo_reg;
        cmd.amp_zero  = trip_reg;
        cmd.kind      = kind_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= 1'b0;
            trip_reg      <= 1'b0;
            kind_reg      <= KIND_NONE;
            code_sel_reg  <= 1'b0;
            echo_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            trip_reg      <= trip_next;
            kind_reg      <= kind_next;
            code_sel_reg  <= code_sel_next;
            echo_reg      <= echo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

FILE: hw/rtl/wpg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpg_datapath
// Sample index, phase divider, waveform shaping, amplitude multiply, result.
// ----------------------------------------------------------------------------
module wpg_datapath
    import wpg_pkg::*;
#(
    parameter int PHASE_BITS         = PHASE_BITS_DEF,
    parameter int SINE_QUARTER_DEPTH = SINE_QUARTER_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  wpg_cfg_t    cfg,
    input  in_item_t    item,
    input  wpg_cmd_t    cmd,
    output wpg_status_t status,
    output out_item_t   result
);

    localparam int DIV_BITS  = INDEX_W + PHASE_BITS;
    localparam int DIV_W     = ((DIV_BITS + 1) / 2) * 2;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int AW        = $clog2(4 * SINE_QUARTER_DEPTH);
    localparam int ROM_N     = SINE_QUARTER_DEPTH + 1;
    localparam int ROM_AW    = $clog2(ROM_N);
    localparam int PP_W      = PHASE_BITS + AW + 1;

    localparam logic [AW:0] Q1       = (AW + 1)'(SINE_QUARTER_DEPTH);
    localparam logic [AW:0] Q2       = (AW + 1)'(2 * SINE_QUARTER_DEPTH);
    localparam logic [AW:0] Q3       = (AW + 1)'(3 * SINE_QUARTER_DEPTH);
    localparam logic [AW:0] FULL_MUL = (AW + 1)'(4 * SINE_QUARTER_DEPTH);
    localparam logic [AW:0] HALF_MUL = (AW + 1)'(2 * SINE_QUARTER_DEPTH);
    localparam logic [CNT_W-1:0] STEPS_INIT = CNT_W'(DIV_STEPS);

    logic [MAG_W-1:0] sine_rom [ROM_N];

    for (genvar g = 0; g < ROM_N; g++)
    begin : g_rom
        localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(g)) / SINE_QUARTER_DEPTH;
        assign sine_rom[g] = sine_q15(ANGLE);
    end

    // captured item
    logic [1:0]       op_reg;
    logic [ADC_W-1:0] volt_reg;
    logic [ADC_W-1:0] curr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= item.operation;
            volt_reg <= item.adc_voltage;
            curr_reg <= item.adc_current;
        end
    end

    // sample index
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [INDEX_W:0]   idx_plus;

    assign idx_plus = {1'b0, idx_reg} + 1'b1;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_plus[INDEX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    // restoring divider, two quotient bits per step; low PHASE_BITS of
    // floor(i * 2^PHASE_BITS / n) are the phase of (i mod n)
    logic [DIV_W-1:0]      div_reg;
    logic [INDEX_W-1:0]    rem_reg;
    logic [PHASE_BITS-1:0] quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [INDEX_W:0]      n_ext;
    logic [INDEX_W:0]      r1_raw, r1, r2_raw, r2;
    logic                  b1, b2;
    logic [PHASE_BITS+1:0] quo_next;

    assign n_ext = {1'b0, cfg.period_n};

    always_comb
    begin
        r1_raw   = {rem_reg, div_reg[DIV_W-1]};
        b1       = (r1_raw >= n_ext);
        r1       = b1 ? (r1_raw - n_ext) : r1_raw;
        r2_raw   = {r1[INDEX_W-1:0], div_reg[DIV_W-2]};
        b2       = (r2_raw >= n_ext);
        r2       = b2 ? (r2_raw - n_ext) : r2_raw;
        quo_next = {quo_reg, b1, b2};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_reg <= DIV_W'({idx_next, {PHASE_BITS{1'b0}}});
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_reg << 2;
            rem_reg <= r2[INDEX_W-1:0];
            quo_reg <= quo_next[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.div_start)
            cnt_reg <= STEPS_INIT;
        else if (cmd.div_step)
            cnt_reg <= cnt_reg - 1'b1;
    end

    // phase stage: sine index, triangle shapes, scaled amplitude
    logic [AW:0]                 sine_mul;
    logic [PP_W-1:0]             phase_prod;
    logic [PHASE_BITS+16:0]      q_wide;
    logic [PHASE_BITS+15:0]      h_wide;
    logic [INDEX_W-1:0]          q;
    logic [15:0]                 h;
    logic [MAG_W-1:0]            tri_mag;
    logic                        tri_neg;
    logic [AMP_W-1:0]            amp_sat;
    logic [AW-1:0]               a_reg;
    logic [MAG_W-1:0]            tri_mag_reg;
    logic                        tri_neg_reg;
    logic [AMP511_W-1:0]         amp511_reg;

    assign sine_mul   = (cfg.wave_type == WAVE_HALF_SINE) ? HALF_MUL : FULL_MUL;
    assign phase_prod = PP_W'(quo_reg) * PP_W'(sine_mul);
    assign q_wide     = {quo_reg, 17'b0} >> PHASE_BITS;
    assign h_wide     = {quo_reg, 16'b0} >> PHASE_BITS;
    assign q          = q_wide[INDEX_W-1:0];
    assign h          = h_wide[15:0];

    always_comb
    begin
        tri_mag = '0;
        tri_neg = 1'b0;
        case (cfg.wave_type)
            WAVE_TRIANGLE:
            begin
                if (q < 17'd32768)
                    tri_mag = q[MAG_W-1:0];
                else if (q <= 17'd65536)
                    tri_mag = MAG_W'(17'd65536 - q);
                else if (q < 17'd98304)
                begin
                    tri_mag = MAG_W'(q - 17'd65536);
                    tri_neg = 1'b1;
                end
                else
                begin
                    tri_mag = MAG_W'(18'd131072 - {1'b0, q});
                    tri_neg = 1'b1;
                end
            end
            WAVE_HALF_TRI:
            begin
                if (h < 16'd32768)
                    tri_mag = h;
                else
                    tri_mag = MAG_W'(17'd65536 - {1'b0, h});
            end
            WAVE_CONST: tri_mag = ONE_Q15;
            default:    tri_mag = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.amp_zero)
            amp_sat = '0;
        else if (cfg.amplitude > FULL_AMP)
            amp_sat = FULL_AMP;
        else
            amp_sat = cfg.amplitude;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.phase)
        begin
            a_reg       <= phase_prod[PHASE_BITS+AW-1:PHASE_BITS];
            tri_mag_reg <= tri_mag;
            tri_neg_reg <= tri_neg;
            amp511_reg  <= {amp_sat, 9'b0} - {9'b0, amp_sat};
        end
    end

    // lookup stage: quarter-wave fold and table read
    logic [AW:0]         a_ext;
    logic [1:0]          quad;
    logic [AW:0]         quad_base;
    logic [AW:0]         k_full;
    logic [ROM_AW-1:0]   rom_addr;
    logic [MAG_W-1:0]    rom_reg;
    logic                sine_neg_reg;

    assign a_ext = {1'b0, a_reg};

    always_comb
    begin
        if (a_ext >= Q3)
        begin
            quad      = 2'd3;
            quad_base = Q3;
        end
        else if (a_ext >= Q2)
        begin
            quad      = 2'd2;
            quad_base = Q2;
        end
        else if (a_ext >= Q1)
        begin
            quad      = 2'd1;
            quad_base = Q1;
        end
        else
        begin
            quad      = 2'd0;
            quad_base = '0;
        end
        k_full   = a_ext - quad_base;
        rom_addr = quad[0] ? ROM_AW'(Q1 - k_full) : ROM_AW'(k_full);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            rom_reg      <= sine_rom[rom_addr];
            sine_neg_reg <= quad[1];
        end
    end

    // multiply stage
    logic                is_sine;
    logic [MAG_W-1:0]    mag;
    logic                wave_neg;
    logic [PROD_W-1:0]   prod_reg;
    logic                neg_reg;

    assign is_sine  = (cfg.wave_type == WAVE_SINE) || (cfg.wave_type == WAVE_HALF_SINE);
    assign mag      = is_sine ? rom_reg : tri_mag_reg;
    assign wave_neg = is_sine ? sine_neg_reg : tri_neg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= {{(PROD_W-AMP511_W){1'b0}}, amp511_reg}
                        * {{(PROD_W-MAG_W){1'b0}}, mag};
            neg_reg  <= wave_neg ^ ~cfg.polarity;
        end
    end

    // result register
    logic [PROD_W-1:0] code_sum;
    out_item_t         result_reg;

    assign code_sum = neg_reg ? (CODE_OFFSET - prod_reg) : (CODE_OFFSET + prod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.dac_code     <= cmd.code_sel ? code_sum[34:25] : MIDSCALE;
            result_reg.report_kind  <= cmd.kind;
            result_reg.voltage_echo <= cmd.echo_sel ? volt_reg : '0;
            result_reg.current_echo <= cmd.echo_sel ? curr_reg : '0;
        end
    end

    assign result = result_reg;

    assign status.op         = op_reg;
    assign status.over_range = (volt_reg == '0) || (volt_reg == ADC_TOP)
                               || (curr_reg == '0) || (curr_reg == ADC_TOP);
    assign status.period_end = (idx_plus >= n_ext);
    assign status.div_done   = (cnt_reg == '0);

endmodule

FILE: hw/rtl/waveform_period_generator.sv
`timescale 1ns / 1ps
// Sequence: an item that yields a sample code goes from decode through the phase divider,
//   at two quotient bits per cycle, then the phase, lookup and multiply stages and the
//   output state into the result register; other items go from decode to the output state.
// Throughput: one item in flight, next transfer the cycle after the result is registered.
// Reset: registers to defaults, idle, not tripped, index 0; no memory clearing pass.
// ----------------------------------------------------------------------------
// waveform_period_generator
// One period of a selected waveform as 10-bit DAC codes with ADC over-range trip.
// ----------------------------------------------------------------------------
`include "waveform_period_generator_macros.svh"

module waveform_period_generator
    import wpg_pkg::*;
#(
    parameter int PHASE_BITS         = PHASE_BITS_DEF,
    parameter int SINE_QUARTER_DEPTH = SINE_QUARTER_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  in_item_t           item,
    output logic               result_valid,
    input  logic               result_ready,
    output out_item_t          result,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    logic [WAVE_W-1:0]  wave_type_reg;
    logic [AMP_W-1:0]   amplitude_reg;
    logic [INDEX_W-1:0] period_reg;
    logic               polarity_reg;
    logic [INDEX_W-1:0] period_n;
    logic               amp_write;
    wpg_cfg_t           cfg;
    wpg_cmd_t           cmd;
    wpg_status_t        status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_type_reg <= RST_WAVE_TYPE;
            amplitude_reg <= RST_AMPLITUDE;
            period_reg    <= RST_PERIOD;
            polarity_reg  <= RST_POLARITY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAVE_TYPE: wave_type_reg <= cfg_data[WAVE_W-1:0];
                REG_AMPLITUDE: amplitude_reg <= cfg_data[AMP_W-1:0];
                REG_PERIOD:    period_reg    <= cfg_data[INDEX_W-1:0];
                REG_POLARITY:  polarity_reg  <= cfg_data[0];
            endcase
        end
    end

    assign amp_write = cfg_we && (cfg_index == REG_AMPLITUDE);

    always_comb
    begin
        if (period_reg < MIN_PERIOD)
            period_n = MIN_PERIOD;
        else if (32'(period_reg) > MAX_PERIOD_SAMPLES)
            period_n = INDEX_W'(MAX_PERIOD_SAMPLES);
        else
            period_n = period_reg;
    end

    assign cfg.wave_type = wave_type_reg;
    assign cfg.amplitude = amplitude_reg;
    assign cfg.period_n  = period_n;
    assign cfg.polarity  = polarity_reg;

    wpg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .amp_write    (amp_write),
        .status       (status),
        .cmd          (cmd)
    );

    wpg_datapath #(
        .PHASE_BITS         (PHASE_BITS),
        .SINE_QUARTER_DEPTH (SINE_QUARTER_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    `WPG_ASSERT_NEXT(a_busy_after_transfer, item_valid && item_ready, !item_ready, "input taken while busy")
    `WPG_ASSERT_IMPLY(a_midscale_on_stop, result_valid && (result.report_kind == KIND_END || result.report_kind == KIND_TRIP), result.dac_code == MIDSCALE, "end or trip not at midscale")
    `WPG_ASSERT_IMPLY(a_echo_only_on_meas, result_valid && result.report_kind != KIND_MEAS && result.report_kind != KIND_END, result.voltage_echo == '0 && result.current_echo == '0, "echo without measurement report")

endmodule

FILE: dv/tb_waveform_period_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waveform_period_generator
// Self-checking bench for the waveform period generator. A directed table
// walks the register extremes, every operation, trips and idle behavior, then
// random start/measure/stop runs cover full periods, trips, restarts and
// noise. Results are checked against table answers or a sample-code predictor.
// ----------------------------------------------------------------------------
module tb_waveform_period_generator;
    import wpg_pkg::*;

    localparam int          Q15_ONE         = 32768;
    localparam int unsigned RANDOM_ITEMS    = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_SETTLE    = 3;
    localparam int unsigned END_SETTLE      = 40;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        logic             is_cfg;
        logic [1:0]       reg_index;
        logic [CFG_W-1:0] reg_value;
        in_item_t         stim;
        logic             typed;
        out_item_t        answer;
    } stim_row_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    in_item_t         item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    out_item_t        result;
    logic             cfg_we       = 1'b0;
    logic [1:0]       cfg_index    = '0;
    logic [CFG_W-1:0] cfg_data     = '0;

    // predictor state
    int unsigned        sine_quarter_q15 [0:SINE_QUARTER_DEPTH_DEF];
    logic [WAVE_W-1:0]  set_wave;
    logic [AMP_W-1:0]   set_amplitude;
    logic [INDEX_W-1:0] set_period;
    logic               set_polarity;
    int unsigned        gen_index;
    bit                 gen_active;
    bit                 trip_latched;

    out_item_t   expected_reports [$];
    stim_row_t   directed_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned random_items   = 0;
    bit          no_idling      = 1'b0;
    bit          hold_request   = 1'b0;

    waveform_period_generator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void build_sine_quarter();
        logic [63:0] x;
        logic [63:0] term;
        longint      acc;
        logic [63:0] rounded;
        int          k;
        int          n;
        for (k = 0; k <= SINE_QUARTER_DEPTH_DEF; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_QUARTER_DEPTH_DEF);
            term = x;
            acc  = $signed(x);
            for (n = 1; n <= 9; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - $signed(term);
                else
                    acc = acc + $signed(term);
            end
            if (acc < 0)
                acc = 0;
            rounded = ($unsigned(acc) * 64'd32768 + (64'd1 << 29)) >> 30;
            if (rounded > 64'd32768)
                rounded = 64'd32768;
            sine_quarter_q15[k] = rounded[31:0];
        end
    endfunction

    function automatic int quarter_sine(input int unsigned a);
        int unsigned quad;
        int unsigned k;
        int          v;
        quad = (a / SINE_QUARTER_DEPTH_DEF) % 4;
        k    = a % SINE_QUARTER_DEPTH_DEF;
        v    = quad[0] ? sine_quarter_q15[SINE_QUARTER_DEPTH_DEF - k] : sine_quarter_q15[k];
        return quad[1] ? -v : v;
    endfunction

    function automatic int wave_level(input logic [63:0] phase);
        int q;
        case (set_wave)
            WAVE_SINE:
                return quarter_sine(int'((phase * 4 * SINE_QUARTER_DEPTH_DEF) >> PHASE_BITS_DEF));
            WAVE_TRIANGLE:
            begin
                q = int'((phase << 17) >> PHASE_BITS_DEF);
                if (q < Q15_ONE)
                    return q;
                if (q < 3 * Q15_ONE)
                    return 2 * Q15_ONE - q;
                return q - 4 * Q15_ONE;
            end
            WAVE_HALF_SINE:
                return quarter_sine(int'((phase * 2 * SINE_QUARTER_DEPTH_DEF) >> PHASE_BITS_DEF));
            WAVE_HALF_TRI:
            begin
                q = int'((phase << 16) >> PHASE_BITS_DEF);
                return (q < Q15_ONE) ? q : 2 * Q15_ONE - q;
            end
            WAVE_CONST:
                return Q15_ONE;
            default:
                return 0;
        endcase
    endfunction

    function automatic int unsigned clamped_period();
        if (set_period < MIN_PERIOD)
            return 32'(MIN_PERIOD);
        if (32'(set_period) > MAX_PERIOD_SAMPLES)
            return MAX_PERIOD_SAMPLES;
        return 32'(set_period);
    endfunction

    function automatic logic [CODE_W-1:0] sample_code(input int unsigned idx);
        int unsigned n;
        logic [63:0] phase;
        longint      amp;
        longint      prod;
        n     = clamped_period();
        phase = (64'(idx % n) << PHASE_BITS_DEF) / 64'(n);
        if (trip_latched)
            amp = 0;
        else if (set_amplitude > FULL_AMP)
            amp = longint'(FULL_AMP);
        else
            amp = longint'(set_amplitude);
        prod = amp * 511 * wave_level(phase);
        if (set_polarity == 1'b0)
            prod = -prod;
        prod = prod + (longint'(MIDSCALE) << 25);
        return prod[34:25];
    endfunction

    function automatic void predict_generator_step(input in_item_t stim, output out_item_t r);
        r = '0;
        r.dac_code    = MIDSCALE;
        r.report_kind = KIND_NONE;
        case (stim.operation)
            OP_START:
            begin
                gen_active = 1'b1;
                gen_index  = 0;
                r.dac_code = sample_code(0);
            end
            OP_MEASURE:
            begin
                if (gen_active)
                begin
                    if (stim.adc_voltage == '0 || stim.adc_voltage == ADC_TOP ||
                        stim.adc_current == '0 || stim.adc_current == ADC_TOP)
                    begin
                        trip_latched  = 1'b1;
                        gen_active    = 1'b0;
                        gen_index     = 0;
                        r.report_kind = KIND_TRIP;
                    end
                    else
                    begin
                        r.voltage_echo = stim.adc_voltage;
                        r.current_echo = stim.adc_current;
                        if (gen_index + 1 >= clamped_period())
                        begin
                            gen_active    = 1'b0;
                            gen_index     = 0;
                            r.report_kind = KIND_END;
                        end
                        else
                        begin
                            gen_index     = gen_index + 1;
                            r.dac_code    = sample_code(gen_index);
                            r.report_kind = KIND_MEAS;
                        end
                    end
                end
            end
            OP_STOP:
            begin
                gen_active = 1'b0;
                gen_index  = 0;
            end
            default:
            begin
                if (gen_active)
                    r.dac_code = sample_code(gen_index);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (no_idling)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic send_item(input in_item_t stim, input logic typed, input out_item_t answer);
        int unsigned gap;
        out_item_t   predicted;
        gap = idle_gap();
        cfg_we <= 1'b0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_generator_step(stim, predicted);
        expected_reports.push_back(typed ? answer : predicted);
        item_valid <= 1'b1;
        item       <= stim;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        cfg_we     <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // leaves cfg_we high so back-to-back writes need no gap
    task automatic write_reg(input logic [1:0] index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            REG_WAVE_TYPE: set_wave = value[WAVE_W-1:0];
            REG_AMPLITUDE:
            begin
                set_amplitude = value[AMP_W-1:0];
                trip_latched  = 1'b0;
            end
            REG_PERIOD:    set_period = value[INDEX_W-1:0];
            default:       set_polarity = value[0];
        endcase
    endtask

    task automatic send_op(input logic [1:0] op, input logic [ADC_W-1:0] volt,
                           input logic [ADC_W-1:0] amps);
        in_item_t stim;
        stim.operation   = op;
        stim.adc_voltage = volt;
        stim.adc_current = amps;
        if (op != OP_MEASURE || gen_active)
            random_items++;
        send_item(stim, 1'b0, '0);
    endtask

    function automatic logic [ADC_W-1:0] clean_reading();
        return ADC_W'($urandom_range(1, 4094));
    endfunction

    function automatic logic [ADC_W-1:0] noisy_reading();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return ADC_TOP;
            default: return ADC_W'($urandom);
        endcase
    endfunction

    task automatic measure_run(input int unsigned count);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 3)
                send_op(OP_HOLD, noisy_reading(), noisy_reading());
            send_op(OP_MEASURE, clean_reading(), clean_reading());
        end
    endtask

    task automatic change_settings(input bit force_amp);
        logic [CFG_W-1:0] value;
        int unsigned      roll;
        if ($urandom_range(0, 9) < 6)
        begin
            roll  = $urandom_range(0, 99);
            value = CFG_W'($urandom);
            if (roll < 75)
                value[WAVE_W-1:0] = WAVE_W'($urandom_range(0, 4));
            else if (roll < 88)
                value[WAVE_W-1:0] = 8'hFF;
            else
                value[WAVE_W-1:0] = WAVE_W'($urandom_range(5, 254));
            write_reg(REG_WAVE_TYPE, value);
        end
        if (force_amp || $urandom_range(0, 9) < 6)
        begin
            roll  = $urandom_range(0, 99);
            value = CFG_W'($urandom);
            if (roll < 10)
                value[AMP_W-1:0] = '0;
            else if (roll < 20)
                value[AMP_W-1:0] = FULL_AMP;
            else if (roll < 30)
                value[AMP_W-1:0] = '1;
            else if (roll < 40)
                value[AMP_W-1:0] = AMP_W'($urandom_range(1025, 2046));
            else
                value[AMP_W-1:0] = AMP_W'($urandom_range(200, 1023));
            write_reg(REG_AMPLITUDE, value);
        end
        if ($urandom_range(0, 1))
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                value = '0;
            else if (roll < 10)
                value = 17'd99;
            else if (roll < 14)
                value = '1;
            else if (roll < 18)
                value = CFG_W'(MAX_PERIOD_SAMPLES);
            else if (roll < 23)
                value = 17'd1000;
            else if (roll < 30)
                value = MIN_PERIOD;
            else
                value = CFG_W'($urandom_range(100, 160));
            write_reg(REG_PERIOD, value);
        end
        if ($urandom_range(0, 1))
            write_reg(REG_POLARITY, CFG_W'($urandom));
    endtask

    function automatic stim_row_t cfg_row(input logic [1:0] index, input logic [CFG_W-1:0] value);
        stim_row_t row;
        row           = '0;
        row.is_cfg    = 1'b1;
        row.reg_index = index;
        row.reg_value = value;
        return row;
    endfunction

    function automatic stim_row_t item_row(input logic [1:0] op, input logic [ADC_W-1:0] volt,
                                           input logic [ADC_W-1:0] amps);
        stim_row_t row;
        row                  = '0;
        row.stim.operation   = op;
        row.stim.adc_voltage = volt;
        row.stim.adc_current = amps;
        return row;
    endfunction

    function automatic stim_row_t checked_row(input logic [1:0] op, input logic [ADC_W-1:0] volt,
                                              input logic [ADC_W-1:0] amps,
                                              input logic [CODE_W-1:0] code, input logic [1:0] kind,
                                              input logic [ADC_W-1:0] v_echo,
                                              input logic [ADC_W-1:0] c_echo);
        stim_row_t row;
        row                     = item_row(op, volt, amps);
        row.typed               = 1'b1;
        row.answer.dac_code     = code;
        row.answer.report_kind  = kind;
        row.answer.voltage_echo = v_echo;
        row.answer.current_echo = c_echo;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // result side: stalls and checking
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        out_item_t   want;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_ready === 1'b1)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", result));
                else
                begin
                    want = expected_reports.pop_front();
                    if (result.dac_code !== want.dac_code)
                        report_mismatch($sformatf("dac_code got %0d want %0d",
                                                  result.dac_code, want.dac_code));
                    if (result.report_kind !== want.report_kind)
                        report_mismatch($sformatf("report_kind got %0d want %0d",
                                                  result.report_kind, want.report_kind));
                    if (result.voltage_echo !== want.voltage_echo)
                        report_mismatch($sformatf("voltage_echo got %0d want %0d",
                                                  result.voltage_echo, want.voltage_echo));
                    if (result.current_echo !== want.current_echo)
                        report_mismatch($sformatf("current_echo got %0d want %0d",
                                                  result.current_echo, want.current_echo));
                end
            end
            if (hold_request)
            begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (stall_left != 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left = idle_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        bit          was_cfg;
        bit          hold_issued;
        int unsigned run_count;
        int unsigned roll;
        logic [ADC_W-1:0] trip_value;

        build_sine_quarter();
        set_wave      = RST_WAVE_TYPE;
        set_amplitude = RST_AMPLITUDE;
        set_period    = RST_PERIOD;
        set_polarity  = RST_POLARITY;
        gen_index     = 0;
        gen_active    = 1'b0;
        trip_latched  = 1'b0;
        was_cfg       = 1'b0;
        hold_issued   = 1'b0;
        run_count     = 0;

        directed_rows = '{
            checked_row(OP_MEASURE, 12'd2000, 12'd2000, MIDSCALE, KIND_NONE, '0, '0),
            checked_row(OP_HOLD, 12'd0, 12'd4095, MIDSCALE, KIND_NONE, '0, '0),
            checked_row(OP_START, 12'd4095, 12'd0, MIDSCALE, KIND_NONE, '0, '0),
            item_row(OP_MEASURE, 12'd1, 12'd4094),
            item_row(OP_MEASURE, 12'd4094, 12'd1),
            item_row(OP_HOLD, 12'd0, 12'd0),
            checked_row(OP_MEASURE, 12'd0, 12'd100, MIDSCALE, KIND_TRIP, '0, '0),
            checked_row(OP_START, 12'd0, 12'd0, MIDSCALE, KIND_NONE, '0, '0),
            checked_row(OP_MEASURE, 12'd100, 12'd4095, MIDSCALE, KIND_TRIP, '0, '0),
            cfg_row(REG_AMPLITUDE, 17'd2047),
            cfg_row(REG_WAVE_TYPE, CFG_W'(WAVE_CONST)),
            checked_row(OP_START, 12'd0, 12'd0, 10'd1023, KIND_NONE, '0, '0),
            checked_row(OP_MEASURE, 12'd4095, 12'd0, MIDSCALE, KIND_TRIP, '0, '0),
            cfg_row(REG_AMPLITUDE, CFG_W'(FULL_AMP)),
            cfg_row(REG_POLARITY, 17'd0),
            checked_row(OP_START, 12'd0, 12'd0, 10'd1, KIND_NONE, '0, '0),
            checked_row(OP_MEASURE, 12'd2048, 12'd2048, 10'd1, KIND_MEAS, 12'd2048, 12'd2048),
            checked_row(OP_STOP, 12'd4095, 12'd4095, MIDSCALE, KIND_NONE, '0, '0),
            cfg_row(REG_WAVE_TYPE, CFG_W'(WAVE_TRIANGLE)),
            cfg_row(REG_PERIOD, 17'd0),
            cfg_row(REG_POLARITY, 17'd1),
            checked_row(OP_START, 12'd0, 12'd0, MIDSCALE, KIND_NONE, '0, '0),
            item_row(OP_MEASURE, 12'd4094, 12'd4094),
            cfg_row(REG_WAVE_TYPE, CFG_W'(WAVE_HALF_SINE)),
            cfg_row(REG_PERIOD, 17'h1FFFF),
            checked_row(OP_START, 12'd0, 12'd0, MIDSCALE, KIND_NONE, '0, '0),
            item_row(OP_MEASURE, 12'd1, 12'd1),
            cfg_row(REG_WAVE_TYPE, CFG_W'(WAVE_HALF_TRI)),
            cfg_row(REG_AMPLITUDE, 17'd0),
            checked_row(OP_START, 12'd0, 12'd0, MIDSCALE, KIND_NONE, '0, '0),
            checked_row(OP_MEASURE, 12'd3000, 12'd1000, MIDSCALE, KIND_MEAS, 12'd3000, 12'd1000),
            cfg_row(REG_WAVE_TYPE, 17'd255),
            cfg_row(REG_AMPLITUDE, CFG_W'(FULL_AMP)),
            checked_row(OP_START, 12'd0, 12'd0, MIDSCALE, KIND_NONE, '0, '0),
            checked_row(OP_MEASURE, 12'd1234, 12'd2345, MIDSCALE, KIND_MEAS, 12'd1234, 12'd2345),
            checked_row(OP_HOLD, 12'd0, 12'd0, MIDSCALE, KIND_NONE, '0, '0)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
            begin
                if (!was_cfg)
                    wait_drained();
                write_reg(directed_rows[r].reg_index, directed_rows[r].reg_value);
            end
            else
                send_item(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].answer);
            was_cfg = directed_rows[r].is_cfg;
        end

        while (random_items < RANDOM_ITEMS)
        begin
            run_count++;
            no_idling = (run_count % 10) >= 8;
            if ($urandom_range(0, 99) < 12 || (trip_latched && $urandom_range(0, 1)))
            begin
                wait_drained();
                change_settings(trip_latched);
            end
            if (!hold_issued && random_items >= 500)
            begin
                // stall results long enough to back up the input side
                hold_request = 1'b1;
                hold_issued  = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 50 && clamped_period() <= 400)
            begin
                send_op(OP_START, ADC_W'($urandom), ADC_W'($urandom));
                measure_run(clamped_period());
            end
            else if (roll < 75)
            begin
                if ($urandom_range(0, 1))
                    send_op(OP_START, ADC_W'($urandom), ADC_W'($urandom));
                measure_run($urandom_range(1, 30));
            end
            else if (roll < 87)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_op(OP_START, ADC_W'($urandom), ADC_W'($urandom));
                measure_run($urandom_range(0, 20));
                trip_value = $urandom_range(0, 1) ? ADC_TOP : '0;
                if ($urandom_range(0, 1))
                    send_op(OP_MEASURE, trip_value, clean_reading());
                else
                    send_op(OP_MEASURE, clean_reading(), trip_value);
            end
            else if (roll < 95)
            begin
                measure_run($urandom_range(0, 10));
                send_op(OP_STOP, ADC_W'($urandom), ADC_W'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    send_op(2'($urandom), noisy_reading(), noisy_reading());
            end
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
